FILE: rtl/core/hrhf_pkg.sv
// Package for the HTTP response header framer.
// Holds character codes, the keyword table and small byte classifiers.
// No dependencies.
package hrhf_pkg;

  // Default width of the parsed content length.
  localparam int unsigned LengthWidthDef = 31;

  // Keyword "Content-Length:" and its length.
  localparam logic [3:0] KeyLen = 4'd15;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChHt    = 8'h09;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // Terminator window: CR LF CR in the last three bytes, newest low.
  localparam logic [23:0] TermWindow = {ChCr, ChLf, ChCr};

  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h43; // C
      4'd1:    ch = 8'h6F; // o
      4'd2:    ch = 8'h6E; // n
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h65; // e
      4'd5:    ch = 8'h6E; // n
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h2D; // -
      4'd8:    ch = 8'h4C; // L
      4'd9:    ch = 8'h65; // e
      4'd10:   ch = 8'h6E; // n
      4'd11:   ch = 8'h67; // g
      4'd12:   ch = 8'h74; // t
      4'd13:   ch = 8'h68; // h
      4'd14:   ch = 8'h3A; // :
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Space, HT, LF, VT, FF, CR.
  function automatic logic is_space(input logic [7:0] ch);
    return (ch == ChSpace) || ((ch >= ChHt) && (ch <= ChCr));
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= ChZero) && (ch <= ChNine);
  endfunction

endpackage

FILE: rtl/core/http_response_header_framer.sv
// Top level of the HTTP response header framer: header terminator search,
// Content-Length parse, body counting and completion flag.
// Depends on hrhf_pkg.
//
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+-------------------------------------
//  in      | in_valid_i  | in_stall_o   | data_byte_i
//  out     | out_valid_o | out_stall_i  | echo_byte_o, is_body_o, header_end_o,
//          |             |              | length_known_o, content_length_o,
//          |             |              | complete_o
//
// One word per cycle sustained unless the output is stalled; each input word
// gives its result word in the cycle after acceptance, from a single output register.
// The input is stalled only while that output register is full and stalled;
// a waiting result is taken and a new word accepted in the same cycle.
// Reset (rst_ni low, asynchronous) clears all framing state and empties
// the output register.
module http_response_header_framer
  import hrhf_pkg::*;
#(
  parameter int unsigned LENGTH_WIDTH = LengthWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [7:0]              data_byte_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [7:0]              echo_byte_o,
  output logic                    is_body_o,
  output logic                    header_end_o,
  output logic                    length_known_o,
  output logic [LENGTH_WIDTH-1:0] content_length_o,
  output logic                    complete_o
);

  // Parse phase codes.
  localparam logic [2:0] PhSearch = 3'd0; // looking for the keyword
  localparam logic [2:0] PhSkip1  = 3'd1; // drop the char after the colon
  localparam logic [2:0] PhBlank  = 3'd2; // blanks or sign
  localparam logic [2:0] PhSign   = 3'd3; // after '+'
  localparam logic [2:0] PhDigits = 3'd4; // reading digits
  localparam logic [2:0] PhDone   = 3'd5; // number finished

  localparam int unsigned AccW = LENGTH_WIDTH + 4;
  localparam int unsigned CmpW = (LENGTH_WIDTH > 32) ? LENGTH_WIDTH : 32;

  // Framing state.
  logic [23:0]             recent_q, recent_d;
  logic [3:0]              match_q, match_d;
  logic [2:0]              phase_q, phase_d;
  logic [LENGTH_WIDTH-1:0] acc_q, acc_d;
  logic                    hdr_seen_q, hdr_seen_d;
  logic [31:0]             count_q, count_d;
  logic [1:0]              hdr_cnt_q, hdr_cnt_d;
  logic                    finished_q, finished_d;

  // Output register.
  logic                    out_valid_q;
  logic [7:0]              echo_q;
  logic                    body_q, body_d;
  logic                    hend_q, hend_d;
  logic                    known_q;
  logic [LENGTH_WIDTH-1:0] clen_q;
  logic                    complete_q;

  logic                    in_acc;
  logic                    out_acc;

  // Digit accumulate: acc*10 + d by shift-add, saturate on overflow.
  logic [AccW-1:0]         acc_ext;
  logic [AccW-1:0]         acc_next;
  logic                    acc_ovf;
  logic [LENGTH_WIDTH-1:0] acc_digit;

  logic                    key_hit;
  logic [3:0]              match_next;
  logic                    term;

  assign out_acc    = out_valid_q && !out_stall_i;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign acc_ext   = {4'b0000, acc_q};
  assign acc_next  = (acc_ext << 3) + (acc_ext << 1) + {{LENGTH_WIDTH{1'b0}}, data_byte_i[3:0]};
  assign acc_ovf   = |acc_next[AccW-1:LENGTH_WIDTH];
  assign acc_digit = acc_ovf ? {LENGTH_WIDTH{1'b1}} : acc_next[LENGTH_WIDTH-1:0];

  assign key_hit    = (match_q < KeyLen) && (data_byte_i == key_char(match_q));
  assign match_next = key_hit ? (match_q + 4'd1)
                              : ((data_byte_i == key_char(4'd0)) ? 4'd1 : 4'd0);

  assign term = (hdr_cnt_q == 2'd3) && (recent_q == TermWindow) && (data_byte_i == ChLf);

  always_comb begin
    recent_d   = recent_q;
    match_d    = match_q;
    phase_d    = phase_q;
    acc_d      = acc_q;
    hdr_seen_d = hdr_seen_q;
    count_d    = count_q;
    hdr_cnt_d  = hdr_cnt_q;
    finished_d = finished_q;
    body_d     = 1'b0;
    hend_d     = 1'b0;

    if (!finished_q) begin
      if (!hdr_seen_q) begin
        // Content-Length parse.
        unique case (phase_q)
          PhSearch: begin
            if (match_next >= KeyLen) begin
              match_d = 4'd0;
              phase_d = PhSkip1;
            end else begin
              match_d = match_next;
            end
          end
          PhSkip1: begin
            phase_d = PhBlank;
          end
          PhBlank: begin
            priority if (is_space(data_byte_i)) begin
              phase_d = PhBlank;
            end else if (data_byte_i == ChPlus) begin
              phase_d = PhSign;
            end else if (is_digit(data_byte_i)) begin
              acc_d   = acc_digit;
              phase_d = PhDigits;
            end else begin
              acc_d   = '0;
              phase_d = PhDone;
            end
          end
          PhSign: begin
            if (is_digit(data_byte_i)) begin
              acc_d   = acc_digit;
              phase_d = PhDigits;
            end else begin
              acc_d   = '0;
              phase_d = PhDone;
            end
          end
          PhDigits: begin
            if (is_digit(data_byte_i)) begin
              acc_d = acc_digit;
            end else begin
              phase_d = PhDone;
            end
          end
          default: begin
          end
        endcase

        // Terminator tracking.
        recent_d = {recent_q[15:0], data_byte_i};
        if (hdr_cnt_q != 2'd3) begin
          hdr_cnt_d = hdr_cnt_q + 2'd1;
        end
        if (term) begin
          hdr_seen_d = 1'b1;
          hend_d     = 1'b1;
          if ((phase_d >= PhSkip1) && (phase_d <= PhDigits)) begin
            phase_d = PhDone;
          end
          if (acc_d == '0) begin
            finished_d = 1'b1;
          end
        end
      end else begin
        // Body byte.
        body_d = 1'b1;
        if (count_q != 32'hFFFF_FFFF) begin
          count_d = count_q + 32'd1;
        end
        if (CmpW'(count_d) == CmpW'(acc_q)) begin
          finished_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q   <= '0;
      match_q    <= '0;
      phase_q    <= PhSearch;
      acc_q      <= '0;
      hdr_seen_q <= 1'b0;
      count_q    <= '0;
      hdr_cnt_q  <= '0;
      finished_q <= 1'b0;
    end else if (in_acc) begin
      recent_q   <= recent_d;
      match_q    <= match_d;
      phase_q    <= phase_d;
      acc_q      <= acc_d;
      hdr_seen_q <= hdr_seen_d;
      count_q    <= count_d;
      hdr_cnt_q  <= hdr_cnt_d;
      finished_q <= finished_d;
    end
  end

  // Output valid: fills on accept, drains when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload, built from the updated state.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      echo_q     <= data_byte_i;
      body_q     <= body_d;
      hend_q     <= hend_d;
      known_q    <= hdr_seen_d && (acc_d != '0);
      clen_q     <= hdr_seen_d ? acc_d : '0;
      complete_q <= finished_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign echo_byte_o      = echo_q;
  assign is_body_o        = body_q;
  assign header_end_o     = hend_q;
  assign length_known_o   = known_q;
  assign content_length_o = clen_q;
  assign complete_o       = complete_q;

  // Completion is sticky once reached.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |=> finished_q)
    else $error("completion flag dropped");

  // A response can only complete after its header.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |-> hdr_seen_q)
    else $error("complete before header end");

  // A word is never both the header terminator and a body byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_body_o && header_end_o))
    else $error("header end flagged on a body byte");

  // A known length is never zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && length_known_o) |-> (content_length_o != '0))
    else $error("length known with zero length");

endmodule
